/* sv/assert_macros.svh */
// assertion macros shared by the deframer modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/lpd_pkg.sv */
// shared types and constants for the length-prefix deframer
// no dependencies; imported by every deframer module
package lpd_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam logic [1:0]  HC_LAST      = 2'(HEADER_BYTES - 1);
    localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_BYTE          = 3'd0,
        ST_EMPTY         = 3'd1,
        ST_OVERSIZE      = 3'd2,
        ST_SHORT_HEADER  = 3'd3,
        ST_SHORT_PAYLOAD = 3'd4,
        ST_SHORT_DISCARD = 3'd5
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_length;
    } result_t;

endpackage

/* sv/lpd_frame_fsm.sv */
// framing state machine: header assembly, payload pass-through and discard
// depends on lpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpd_frame_fsm
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic [31:0] max_len,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] shifted_len;
    logic        left_le_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 2'd0;
            length_reg       <= 32'd0;
            bytes_left_reg   <= 32'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            length_reg       <= length_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    assign shifted_len = {length_reg[23:0], data_byte};
    assign left_le_one = (bytes_left_reg[31:1] == 31'd0);

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        length_next       = length_reg;
        bytes_left_next   = bytes_left_reg;
        res_valid         = 1'b0;
        res.status        = ST_BYTE;
        res.payload_byte  = 8'd0;
        res.last_of_frame = 1'b0;
        res.frame_length  = length_reg;

        if (accept)
        begin
            if (op)
            begin
                // end of stream: report what was cut short, back to idle
                res_valid = 1'b1;
                unique case (phase_reg)
                    PH_PAYLOAD: res.status = ST_SHORT_PAYLOAD;
                    PH_DISCARD: res.status = ST_SHORT_DISCARD;
                    default:
                    begin
                        res.status       = ST_SHORT_HEADER;
                        res.frame_length = 32'd0;
                    end
                endcase
                phase_next        = PH_HEADER;
                header_count_next = 2'd0;
                length_next       = 32'd0;
                bytes_left_next   = 32'd0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        res_valid         = 1'b1;
                        res.payload_byte  = data_byte;
                        res.last_of_frame = left_le_one;
                        if (left_le_one)
                        begin
                            phase_next      = PH_HEADER;
                            length_next     = 32'd0;
                            bytes_left_next = 32'd0;
                        end
                        else
                        begin
                            bytes_left_next = bytes_left_reg - 32'd1;
                        end
                    end
                    PH_DISCARD:
                    begin
                        if (left_le_one)
                        begin
                            res_valid       = 1'b1;
                            res.status      = ST_OVERSIZE;
                            phase_next      = PH_HEADER;
                            length_next     = 32'd0;
                            bytes_left_next = 32'd0;
                        end
                        else
                        begin
                            bytes_left_next = bytes_left_reg - 32'd1;
                        end
                    end
                    default:
                    begin
                        phase_next  = PH_HEADER;
                        length_next = shifted_len;
                        if (header_count_reg != HC_LAST)
                        begin
                            header_count_next = header_count_reg + 2'd1;
                        end
                        else
                        begin
                            header_count_next = 2'd0;
                            if (shifted_len > max_len)
                            begin
                                phase_next      = PH_DISCARD;
                                bytes_left_next = shifted_len;
                            end
                            else if (shifted_len == 32'd0)
                            begin
                                res_valid        = 1'b1;
                                res.status       = ST_EMPTY;
                                res.frame_length = 32'd0;
                                length_next      = 32'd0;
                                bytes_left_next  = 32'd0;
                            end
                            else
                            begin
                                phase_next      = PH_PAYLOAD;
                                bytes_left_next = shifted_len;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // header bytes are only counted while assembling a header
    `LPD_ASSERT_IMPL(a_count_in_header, clk, rst_n,
        header_count_reg != 2'd0, phase_reg == PH_HEADER)
    // payload and discard always have bytes still due
    `LPD_ASSERT_IMPL(a_left_nonzero, clk, rst_n,
        phase_reg != PH_HEADER, bytes_left_reg != 32'd0)
    // end of stream returns everything to the idle header state
    `LPD_ASSERT_NEXT(a_end_to_idle, clk, rst_n, accept && op,
        phase_reg == PH_HEADER && header_count_reg == 2'd0 && length_reg == 32'd0)

endmodule

/* sv/lpd_out_stage.sv */
// result register with one skid entry between the state machine and the receiver
// depends on lpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpd_out_stage
    import lpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            // output slot frees up: skid entry goes first
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // the skid entry is only used behind a held output
    `LPD_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // nothing arrives while the skid entry is full
    `LPD_ASSERT_IMPL(a_no_overrun, clk, rst_n, skid_valid_reg, !res_valid)

endmodule

/* sv/length_prefix_deframer_unit.sv */
// length-prefix deframer, top level
// depends on lpd_pkg, lpd_frame_fsm and lpd_out_stage
//
// usage:
//   input channel (in_valid / in_stall, op, data_byte): one stream byte per
//   transfer with op low, or an end-of-stream marker with op high
//   output channel (out_valid / out_stall, status, payload_byte,
//   last_of_frame, frame_length): zero or one result per input transfer
//   config: cfg_wr_en / cfg_wr_data write the maximum payload length,
//   only while the block is idle
// a result is registered before it is presented, via the skid entry if the receiver stalls
// throughput: one input transfer per cycle while in_stall is low; the framing
//   state is a handful of counters updated by a single pass of logic each byte
// each stream frame is a 4-byte big-endian length, then the payload;
//   payload bytes come out as they arrive, last one marked
// oversize frames are skipped and flagged once after the last skipped byte
// reset: state goes to the start of a header, max length to 4096,
//   no results pending
// stall: a result register plus one skid entry absorb a stalled receiver;
//   in_stall rises only once the skid entry holds a result
module length_prefix_deframer_unit
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  payload_byte,
    output logic        last_of_frame,
    output logic [31:0] frame_length,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0] max_len_reg;
    logic        accept;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    // maximum payload length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // input transfer completes when valid and the skid entry is free
    assign accept = in_valid && !in_stall;

    lpd_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .data_byte (data_byte),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // unpack the result onto the output ports
    assign status        = out_res.status;
    assign payload_byte  = out_res.payload_byte;
    assign last_of_frame = out_res.last_of_frame;
    assign frame_length  = out_res.frame_length;

endmodule

/* tb/testbench.sv */
// self-checking testbench for length_prefix_deframer_unit
// depends on lpd_pkg and the deframer rtl; drives framed byte streams and
// checks every result against an in-bench model of the deframer
`timescale 1ns / 100ps

module testbench;
    import lpd_pkg::*;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 4;
    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } stream_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [31:0] frame_length;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;

    // stimulus waiting to be offered, results waiting to be seen
    stream_item_t stream_items[$];
    result_t      due_results[$];

    // model state of the deframer
    phase_t      frame_phase = PH_HEADER;
    logic [1:0]  hdr_taken = 2'd0;
    logic [31:0] len_word = 32'h0;
    logic [31:0] bytes_due = 32'h0;
    logic [31:0] max_len = MAX_LEN_RESET;

    // flow control knobs, set on the falling edge; the hold countdown runs on the rising edge
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int items_queued = 0;
    int transfers_in = 0;
    int results_seen = 0;
    int fail_count = 0;
    int status_tally [0:5];

    length_prefix_deframer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .frame_length  (frame_length),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // deframer model
    // ---------------------------------------------------------------

    function automatic result_t make_result(status_t st, logic [7:0] b, logic last,
                                            logic [31:0] flen);
        result_t r;
        r.status        = st;
        r.payload_byte  = b;
        r.last_of_frame = last;
        r.frame_length  = flen;
        return r;
    endfunction

    function automatic void return_to_header();
        frame_phase = PH_HEADER;
        hdr_taken   = 2'd0;
        len_word    = 32'h0;
        bytes_due   = 32'h0;
    endfunction

    // one accepted transfer in, zero or one expected result out
    function automatic void predict_deframe(logic op_i, logic [7:0] data_i);
        if (op_i == OP_END)
        begin
            // end of stream reports what was cut short, even with nothing taken
            case (frame_phase)
                PH_PAYLOAD: due_results.push_back(make_result(ST_SHORT_PAYLOAD, 8'h00,
                                                              1'b0, len_word));
                PH_DISCARD: due_results.push_back(make_result(ST_SHORT_DISCARD, 8'h00,
                                                              1'b0, len_word));
                default:    due_results.push_back(make_result(ST_SHORT_HEADER, 8'h00,
                                                              1'b0, 32'h0));
            endcase
            return_to_header();
        end
        else if (frame_phase == PH_PAYLOAD)
        begin
            due_results.push_back(make_result(ST_BYTE, data_i, (bytes_due <= 32'd1),
                                              len_word));
            if (bytes_due <= 32'd1)
                return_to_header();
            else
                bytes_due = bytes_due - 32'd1;
        end
        else if (frame_phase == PH_DISCARD)
        begin
            // oversize flag follows the last skipped byte
            if (bytes_due <= 32'd1)
            begin
                due_results.push_back(make_result(ST_OVERSIZE, 8'h00, 1'b0, len_word));
                return_to_header();
            end
            else
                bytes_due = bytes_due - 32'd1;
        end
        else
        begin
            // header byte, big-endian shift into the length word
            frame_phase = PH_HEADER;
            len_word = {len_word[23:0], data_i};
            if (hdr_taken != HC_LAST)
                hdr_taken = hdr_taken + 2'd1;
            else
            begin
                hdr_taken = 2'd0;
                if (len_word > max_len)
                begin
                    frame_phase = PH_DISCARD;
                    bytes_due   = len_word;
                end
                else if (len_word == 32'h0)
                begin
                    due_results.push_back(make_result(ST_EMPTY, 8'h00, 1'b0, 32'h0));
                    return_to_header();
                end
                else
                begin
                    frame_phase = PH_PAYLOAD;
                    bytes_due   = len_word;
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // input driver: offers queued items, predicts on each transfer
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : drive_stream
        stream_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_deframe(op, data_byte);
                transfers_in++;
            end
            // a stalled item stays put; otherwise offer the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (stream_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = stream_items.pop_front();
                    in_valid  <= 1'b1;
                    op        <= nxt.op;
                    data_byte <= nxt.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver stall: random, or a long hold when one is requested
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_requests != hold_served)
            begin
                hold_served <= hold_requests;
                hold_left   <= HOLD_CYCLES;
                out_stall   <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // result monitor: each output transfer against the oldest expectation
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result status %0d byte %02h last %0b len %0d",
                             $time, status, payload_byte, last_of_frame, frame_length);
            end
            else
            begin
                want = due_results.pop_front();
                results_seen++;
                status_tally[want.status]++;
                if (status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, status);
                end
                if (payload_byte !== want.payload_byte)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: payload_byte expected %02h got %02h",
                                 $time, want.payload_byte, payload_byte);
                end
                if (last_of_frame !== want.last_of_frame)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: last_of_frame expected %0b got %0b",
                                 $time, want.last_of_frame, last_of_frame);
                end
                if (frame_length !== want.frame_length)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: frame_length expected %08h got %08h",
                                 $time, want.frame_length, frame_length);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic void push_byte(logic [7:0] b);
        stream_item_t it;
        it.op   = OP_BYTE;
        it.data = b;
        stream_items.push_back(it);
        items_queued++;
    endfunction

    // data byte rides along with an end marker and must be ignored
    function automatic void push_end(logic [7:0] b);
        stream_item_t it;
        it.op   = OP_END;
        it.data = b;
        stream_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_header(logic [31:0] len);
        push_byte(len[31:24]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endfunction

    // frame lengths cluster around the current maximum when it is small
    function automatic logic [31:0] pick_frame_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r == 1 && max_len <= 32'd20)
            return max_len;
        if (r == 2 && max_len < 32'd20)
            return max_len + 32'd1;
        if (max_len < 32'd20)
            return $urandom_range(1, max_len + 3);
        return $urandom_range(1, 12);
    endfunction

    // mostly whole frames, then cut-off frames, lone ends and junk bytes
    task automatic add_random_stream(int budget);
        int          stop_at;
        int          kind;
        int          h;
        int          k;
        logic [31:0] len;
        stop_at = items_queued + budget;
        while (items_queued < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = pick_frame_len();
                push_header(len);
                repeat (len) push_byte(8'($urandom_range(0, 255)));
            end
            else if (kind < 75)
            begin
                h = $urandom_range(0, 4);
                if (h < 4)
                    repeat (h) push_byte(8'($urandom_range(0, 255)));
                else
                begin
                    len = $urandom_range(0, 1) ? $urandom() : pick_frame_len();
                    push_header(len);
                    k = $urandom_range(0, 5);
                    if (len <= k)
                        k = (len == 0) ? 0 : int'(len) - 1;
                    repeat (k) push_byte(8'($urandom_range(0, 255)));
                end
                push_end(8'($urandom_range(0, 255)));
            end
            else if (kind < 85)
                push_end(8'($urandom_range(0, 255)));
            else
            begin
                // junk may assemble a huge length, so resync with an end
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                push_end(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic set_flow(int send_pct, int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // waits until every item is sent and every expected result is back, then the tail
    task automatic drain_stream();
        @(negedge clk);
        while (stream_items.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(logic [31:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        max_len = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------

    initial
    begin
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset maximum of 4096
        push_header(32'h0);                 // empty frame
        push_end(8'hFF);                    // end in idle
        push_byte(8'h12);
        push_byte(8'h34);
        push_end(8'h00);                    // end mid-header
        push_header(32'd1);
        push_end(8'h5A);                    // end mid-payload
        drain_stream();

        // directed, maximum of one
        write_max_len(32'd1);
        push_header(32'd1);
        push_byte(8'hFF);                   // length equal to maximum
        push_header(32'd3);
        push_byte(8'h5A);
        push_end(8'hA5);                    // end mid-discard
        drain_stream();

        // full rate, no limit on length, with a long receiver hold
        write_max_len(32'hFFFF_FFFF);
        set_flow(0, 0);
        hold_requests = hold_requests + 1;
        add_random_stream(85);
        drain_stream();

        // everything nonzero is oversize, sender idles
        write_max_len(32'h0);
        set_flow(59, 0);
        add_random_stream(85);
        drain_stream();

        write_max_len(32'd6);
        set_flow(0, 59);
        add_random_stream(85);
        drain_stream();

        write_max_len(32'd12);
        set_flow(24, 24);
        add_random_stream(85);
        drain_stream();

        write_max_len(32'd15);
        set_flow(0, 0);
        add_random_stream(85);
        drain_stream();

        $display("covered %0d input transfers over seven length limits and four idle mixes",
                 transfers_in);
        $display("checked %0d results: %0d bytes, %0d empty, %0d oversize, %0d cut short",
                 results_seen, status_tally[ST_BYTE], status_tally[ST_EMPTY],
                 status_tally[ST_OVERSIZE],
                 status_tally[ST_SHORT_HEADER] + status_tally[ST_SHORT_PAYLOAD]
                 + status_tally[ST_SHORT_DISCARD]);
        if (fail_count == 0)
            $display("[length_prefix_deframer_unit] OK");
        else
            $display("[length_prefix_deframer_unit] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("[length_prefix_deframer_unit] ERROR");
        $finish;
    end

endmodule
